### sv/sks_pkg.sv
// Package for the sorted key set: sizes, command and status codes,
// cell and sequencer control types.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package sks_pkg;

    // Store size and key width
    localparam int CAPACITY = 64;
    localparam int KEY_BITS = 32;

    // Fixed port field widths
    localparam int CMD_W    = 3;
    localparam int PKEY_W   = 32;
    localparam int PIDX_W   = 6;
    localparam int STATUS_W = 3;
    localparam int SIZE_W   = 7;
    localparam int S_DATA_W = 48;
    localparam int M_DATA_W = 48;

    // Derived widths
    localparam int IDX_W     = $clog2(CAPACITY);
    localparam int CNT_W     = $clog2(CAPACITY + 1);
    localparam int IDX_CMP_W = (IDX_W > PIDX_W) ? IDX_W : PIDX_W;

    typedef logic [KEY_BITS-1:0] key_t;
    typedef logic [CNT_W-1:0]    count_t;

    typedef enum logic [CMD_W-1:0] {
        CMD_ADD      = 3'd0,
        CMD_REMOVE   = 3'd1,
        CMD_CONTAINS = 3'd2,
        CMD_CLEAR    = 3'd3,
        CMD_READ     = 3'd4
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 3'd0,
        ST_DUP      = 3'd1,
        ST_NOTFOUND = 3'd2,
        ST_FULL     = 3'd3,
        ST_RANGE    = 3'd4
    } status_t;

    // What every cell does in the update cycle
    typedef enum logic [1:0] {
        OP_HOLD,
        OP_INSERT,
        OP_REMOVE,
        OP_CLEAR
    } cell_op_t;

    typedef struct packed {
        logic     cmp;   // latch compare flags against the probe key
        cell_op_t op;    // update applied in the update cycle
    } cell_ctrl_t;

    // Sequencer states and strobes
    typedef enum logic [1:0] {
        S_IDLE,
        S_CMP,
        S_UPD
    } seq_state_t;

    typedef struct packed {
        logic load;      // capture input beat
        logic cmp;       // cells compare
        logic upd;       // cells update, result register loads
    } seq_t;

endpackage

`default_nettype wire

### sv/sks_cell.sv
// One storage cell of the sorted key chain: holds a key and its valid bit,
// compares against the probe key and shifts with its left and right neighbors.
// Depends on sks_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sks_cell (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire sks_pkg::cell_ctrl_t ctrl,
    input  wire sks_pkg::key_t      probe,
    input  wire logic               sel,
    input  wire sks_pkg::key_t      left_key,
    input  wire logic               left_lt,
    input  wire logic               left_valid,
    input  wire sks_pkg::key_t      right_key,
    input  wire logic               right_valid,
    output sks_pkg::key_t           key,
    output logic                    valid,
    output logic                    lt,
    output logic                    eq,
    output logic                    hit,
    output sks_pkg::key_t           rd
);
    import sks_pkg::*;

    key_t key_reg, key_next;
    logic valid_reg, valid_next;
    logic lt_reg, eq_reg, sel_reg;

    // Key storage follows the chain op
    always_comb
    begin
        key_next   = key_reg;
        valid_next = valid_reg;
        unique case (ctrl.op)
            OP_HOLD:
            begin
                key_next   = key_reg;
                valid_next = valid_reg;
            end
            OP_INSERT:
            begin
                if (!lt_reg)
                begin
                    key_next = left_lt ? probe : left_key;
                    if (!left_lt && !left_valid)
                        key_next = key_reg;
                    key_next   = (!left_lt && left_valid) ? left_key : key_next;
                    key_next   = (left_lt || !left_valid) ? probe : key_next;
                end
                valid_next = valid_reg | left_valid;
            end
            OP_REMOVE:
            begin
                if (!lt_reg)
                    key_next = right_key;
                valid_next = right_valid;
            end
            OP_CLEAR:
            begin
                valid_next = 1'b0;
            end
            default:
            begin
                key_next   = key_reg;
                valid_next = valid_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            lt_reg    <= 1'b0;
            eq_reg    <= 1'b0;
            sel_reg   <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            if (ctrl.cmp)
            begin
                lt_reg  <= valid_reg && (key_reg < probe);
                eq_reg  <= valid_reg && (key_reg == probe);
                sel_reg <= valid_reg && sel;
            end
        end
    end

    assign key   = key_reg;
    assign valid = valid_reg;
    assign lt    = lt_reg;
    assign eq    = eq_reg;
    assign hit   = sel_reg;
    assign rd    = sel_reg ? key_reg : '0;

endmodule

`default_nettype wire

### sv/sks_ctrl.sv
// Sequencer of the sorted key set: accept, compare, update.
// Depends on sks_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sks_ctrl (
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    in_valid,
    input  wire logic    out_free,
    output logic         in_ready,
    output sks_pkg::seq_t seq
);
    import sks_pkg::*;

    seq_state_t state_reg, state_next;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:  state_next = in_valid ? S_CMP : S_IDLE;
            S_CMP:   state_next = S_UPD;
            S_UPD:   state_next = out_free ? S_IDLE : S_UPD;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    // Outputs
    always_comb
    begin
        in_ready = 1'b0;
        seq      = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                seq.load = in_valid;
            end
            S_CMP:   seq.cmp = 1'b1;
            S_UPD:   seq.upd = out_free;
            default: in_ready = 1'b0;
        endcase
    end

endmodule

`default_nettype wire

### sv/sorted_key_set_unit.sv
// Top level of the sorted key set: a chain of key cells kept in ascending
// order, with a sequencer and a registered result beat.
// Depends on sks_pkg, sks_cell, sks_ctrl.
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+--------------------------------------
//  s_*     | in  | s_tvalid/s_tready  | s_tdata: cmd, key, index
//  m_*     | out | m_tvalid/m_tready  | m_tdata: status, found, read_value, size
//
// Each command runs through accept, a parallel compare in every cell,
// then an update step in which cells shift with their neighbors and the
// result register loads. The update waits while the previous result beat is
// still held; a new beat is accepted while a result is waiting.
// Reset empties the set at once (cell valid bits clear); keys need no reset.
`timescale 1ns / 1ps
`default_nettype none

module sorted_key_set_unit (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // [2:0] cmd, [34:3] key, [40:35] index, [47:41] zero
    input  wire logic [sks_pkg::S_DATA_W-1:0] s_tdata,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // [2:0] status, [3] found, [35:4] read_value, [42:36] size_now, [47:43] zero
    output logic [sks_pkg::M_DATA_W-1:0] m_tdata
);
    import sks_pkg::*;

    // Captured command
    logic [CMD_W-1:0]  cmd_reg;
    key_t              probe_reg;
    logic [PIDX_W-1:0] idx_reg;
    count_t            held_reg, held_next;

    // Result register
    logic              m_tvalid_reg, m_tvalid_next;
    logic [M_DATA_W-1:0] m_tdata_reg, m_tdata_next;

    seq_t       seq;
    cell_ctrl_t cctrl;
    cell_op_t   op;
    logic       out_free;

    key_t key_v [CAPACITY];
    key_t rd_v  [CAPACITY];
    logic [CAPACITY-1:0] valid_v, lt_v, eq_v, hit_v;

    assign out_free = !m_tvalid_reg || m_tready;

    sks_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .out_free (out_free),
        .in_ready (s_tready),
        .seq      (seq)
    );

    // Input capture
    always_ff @(posedge clk)
    begin
        if (seq.load)
        begin
            cmd_reg   <= s_tdata[CMD_W-1:0];
            probe_reg <= key_t'(s_tdata[CMD_W+PKEY_W-1:CMD_W]);
            idx_reg   <= s_tdata[CMD_W+PKEY_W+PIDX_W-1:CMD_W+PKEY_W];
        end
    end

    assign cctrl.cmp = seq.cmp;
    assign cctrl.op  = seq.upd ? op : OP_HOLD;

    // Cell chain
    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++)
        begin : g_cell
            key_t lk, rk;
            logic llt, lval, rval, sel;

            if (gi == 0)
            begin : g_first
                assign lk   = probe_reg;
                assign llt  = 1'b0;
                assign lval = 1'b1;
            end
            else
            begin : g_mid_l
                assign lk   = key_v[gi-1];
                assign llt  = lt_v[gi-1];
                assign lval = valid_v[gi-1];
            end

            if (gi == CAPACITY - 1)
            begin : g_last
                assign rk   = '0;
                assign rval = 1'b0;
            end
            else
            begin : g_mid_r
                assign rk   = key_v[gi+1];
                assign rval = valid_v[gi+1];
            end

            assign sel = (IDX_CMP_W'(idx_reg) == IDX_CMP_W'(gi));

            sks_cell u_cell (
                .clk         (clk),
                .rst_n       (rst_n),
                .ctrl        (cctrl),
                .probe       (probe_reg),
                .sel         (sel),
                .left_key    (lk),
                .left_lt     (llt),
                .left_valid  (lval),
                .right_key   (rk),
                .right_valid (rval),
                .key         (key_v[gi]),
                .valid       (valid_v[gi]),
                .lt          (lt_v[gi]),
                .eq          (eq_v[gi]),
                .hit         (hit_v[gi]),
                .rd          (rd_v[gi])
            );
        end
    endgenerate

    // Flag reduction over the chain
    logic any_eq, any_hit, is_full;
    key_t rd_any;

    always_comb
    begin
        rd_any = '0;
        for (int i = 0; i < CAPACITY; i++)
            rd_any = rd_any | rd_v[i];
    end

    assign any_eq  = |eq_v;
    assign any_hit = |hit_v;
    assign is_full = (held_reg == count_t'(CAPACITY));

    // Command decode and result
    status_t status;
    logic    found;
    key_t    rv;

    always_comb
    begin
        op        = OP_HOLD;
        status    = ST_OK;
        found     = 1'b0;
        rv        = '0;
        held_next = held_reg;
        unique case (cmd_reg)
            CMD_ADD:
            begin
                if (any_eq)
                    status = ST_DUP;
                else if (is_full)
                    status = ST_FULL;
                else
                begin
                    op        = OP_INSERT;
                    held_next = held_reg + count_t'(1);
                end
            end
            CMD_REMOVE:
            begin
                if (any_eq)
                begin
                    op        = OP_REMOVE;
                    held_next = held_reg - count_t'(1);
                end
                else
                    status = ST_NOTFOUND;
            end
            CMD_CONTAINS: found = any_eq;
            CMD_CLEAR:
            begin
                op        = OP_CLEAR;
                held_next = '0;
            end
            CMD_READ:
            begin
                if (any_hit)
                    rv = rd_any;
                else
                    status = ST_RANGE;
            end
            default: op = OP_HOLD;
        endcase
    end

    always_comb
    begin
        m_tdata_next = '0;
        m_tdata_next[STATUS_W-1:0]                   = status;
        m_tdata_next[STATUS_W]                       = found;
        m_tdata_next[STATUS_W+PKEY_W:STATUS_W+1]     = PKEY_W'(rv);
        m_tdata_next[STATUS_W+PKEY_W+SIZE_W:STATUS_W+PKEY_W+1] = SIZE_W'(held_next);
    end

    always_comb
    begin
        if (seq.upd)
            m_tvalid_next = 1'b1;
        else if (m_tready)
            m_tvalid_next = 1'b0;
        else
            m_tvalid_next = m_tvalid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            m_tvalid_reg <= m_tvalid_next;
            if (seq.upd)
                held_reg <= held_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (seq.upd)
            m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

`default_nettype wire
